// ===== rtl/int_key_chained_hash_table_unit_assert.svh =====
// Assertion macros shared by the hash table RTL.
// Included by the top level; no other dependencies.
`ifndef INT_KEY_CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define INT_KEY_CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define IKH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define IKH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/ikh_pkg.sv =====
// Package for the integer key hash table: sizes, codes, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package ikh_pkg;
   localparam int NumBuckets  = 16;
   localparam int BucketDepth = 8;
   localparam int SlotTotal   = NumBuckets * BucketDepth;
   localparam int BktW        = $clog2(NumBuckets);
   localparam int PosW        = $clog2(BucketDepth);
   localparam int FillW       = $clog2(BucketDepth + 1);
   localparam int SlotW       = $clog2(SlotTotal);
   localparam int CntW        = 8;

   localparam logic [1:0] MODE_SET = 2'd0;
   localparam logic [1:0] MODE_GET = 2'd1;
   localparam logic [1:0] MODE_DEL = 2'd2;

   localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;

   typedef struct packed {
      logic start;     // latch request, begin hashing
      logic rd;        // issue read of entry at pos
      logic chk;       // compare read data
      logic wr_set;    // write key/value at pos (set)
      logic shift_rd;  // read entry pos+1 for shift
      logic shift_wr;  // write shifted entry at pos, advance pos
      logic commit;    // update counts, form result
      logic pos_inc;   // advance scan position
   } ikh_cmd_type;

   typedef struct packed {
      logic hash_done;
      logic at_fill;   // pos == fill
      logic hit;       // compare matched
      logic full;      // fill == depth
      logic shift_end; // pos+1 >= fill
      logic [1:0] mode;
   } ikh_sts_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
   endfunction
endpackage

// ===== rtl/ikh_if.sv =====
// Valid/ready channel interfaces for requests (mode, key, value) and for responses.
// Depends on nothing.
`timescale 1ns / 1ps
interface ikh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic signed [31:0] key;
   logic [31:0] value;
   modport source (output valid, mode, key, value, input ready);
   modport sink (input valid, mode, key, value, output ready);
endinterface

interface ikh_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] value_out;
   logic        status;
   logic [3:0]  bucket_index;
   logic [7:0]  entry_count;
   modport source (output valid, found, value_out, status, bucket_index, entry_count,
                   input ready);
   modport sink (input valid, found, value_out, status, bucket_index, entry_count,
                 output ready);
endinterface

// ===== rtl/ikh_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ikh_ram #(
   parameter int Width = 32,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/ikh_datapath.sv =====
// Datapath: request latch, serial hash and modulo, bucket fill counts, entry RAMs.
// Depends on ikh_pkg and ikh_ram.
`timescale 1ns / 1ps
module ikh_datapath
   import ikh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ikh_cmd_type       cmd,
   output ikh_sts_type       sts,
   input  logic [1:0]        req_mode,
   input  logic [31:0]       req_key,
   input  logic [31:0]       req_value,
   input  logic [4:0]        bucket_count,
   output logic              res_found,
   output logic [31:0]       res_value,
   output logic              res_status,
   output logic [3:0]        res_bucket,
   output logic [CntW-1:0]   res_count
);
   typedef enum logic [1:0] {H_IDLE, H_TEXT, H_MOD, H_DONE} hstate_type;

   logic [1:0]  mode_ff;
   logic [31:0] key_ff, val_ff;
   logic [31:0] sh_ff, sh_in;          // remaining key nibbles, msb first
   logic [3:0]  ncnt_ff, ncnt_in;      // nibbles left, then shift amount
   logic        started_ff, started_in;
   logic [3:0]  len_ff, len_in;        // characters emitted
   logic [7:0]  lo_ff, lo_in;
   logic [23:0] h_ff, h_in;
   logic [4:0]  nb_ff;
   hstate_type  hstate_ff, hstate_in;
   logic [BktW-1:0]  bkt_ff;
   logic [FillW-1:0] fill_ff;
   logic [FillW-1:0] pos_ff;           // reaches BucketDepth when a full bucket misses
   logic [FillW-1:0] fill_mem_ff [NumBuckets];
   logic [CntW-1:0]  total_ff;
   logic        hit_ff, full_ff, stat_ff;
   logic [31:0] vout_ff;

   logic [SlotW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   logic [31:0] k_rd, v_rd, k_wd, v_wd;
   logic [3:0]  nib;
   logic [7:0]  ch;
   logic [15:0] unit;
   logic [3:0]  uidx;
   logic [4:0]  nbs;

   assign nbs = (bucket_count == 5'd0) ? 5'd1 :
                (bucket_count > 5'(NumBuckets)) ? 5'(NumBuckets) : bucket_count;
   assign nib  = sh_ff[31:28];
   assign ch   = hex_char(nib);
   assign uidx = len_ff >> 1;
   assign unit = {ch, lo_ff};

   always_comb begin
      sh_in = sh_ff; ncnt_in = ncnt_ff; started_in = started_ff;
      len_in = len_ff; lo_in = lo_ff; h_in = h_ff; hstate_in = hstate_ff;
      if (cmd.start) begin
         sh_in = req_key; ncnt_in = 4'd8; started_in = 1'b0; len_in = 4'd0;
         h_in = 24'd0; hstate_in = H_TEXT;
      end else if (hstate_ff == H_TEXT) begin
         if (ncnt_ff == 4'd0) begin
            if (len_ff[0]) begin
               h_in = h_ff ^ (24'({8'd0, lo_ff}) << uidx);
            end
            ncnt_in = 4'd15;
            hstate_in = H_MOD;
         end else begin
            sh_in = sh_ff << 4;
            ncnt_in = ncnt_ff - 4'd1;
            if (nib != 4'd0 || started_ff || ncnt_ff == 4'd1) begin
               started_in = 1'b1;
               len_in = len_ff + 4'd1;
               if (len_ff[0]) begin
                  h_in = h_ff ^ (24'(unit) << uidx);
               end else begin
                  lo_in = ch;
               end
            end
         end
      end else if (hstate_ff == H_MOD) begin
         // restoring reduction: subtract nb shifted while it fits, then lower the shift
         if ((h_ff >> ncnt_ff) >= {19'd0, nb_ff}) begin
            h_in = h_ff - ({19'd0, nb_ff} << ncnt_ff);
         end else if (ncnt_ff == 4'd0) begin
            hstate_in = H_DONE;
         end else begin
            ncnt_in = ncnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hstate_ff <= H_IDLE;
         total_ff <= '0;
         for (int i = 0; i < NumBuckets; i++) fill_mem_ff[i] <= '0;
      end else begin
         hstate_ff <= (cmd.rd && hstate_ff == H_DONE) ? H_IDLE : hstate_in;
         if (cmd.commit && mode_ff == MODE_SET && !hit_ff && !full_ff) begin
            fill_mem_ff[bkt_ff] <= fill_ff + 1'b1;
            total_ff <= total_ff + 1'b1;
         end
         if (cmd.commit && mode_ff == MODE_DEL && hit_ff) begin
            fill_mem_ff[bkt_ff] <= fill_ff - 1'b1;
            if (total_ff != '0) total_ff <= total_ff - 1'b1;
         end
      end
      sh_ff <= sh_in; ncnt_ff <= ncnt_in; started_ff <= started_in;
      len_ff <= len_in; lo_ff <= lo_in; h_ff <= h_in;
      if (cmd.start) begin
         mode_ff <= req_mode; key_ff <= req_key; val_ff <= req_value; nb_ff <= nbs;
         hit_ff <= 1'b0; stat_ff <= 1'b0; vout_ff <= '0;
      end
      if (hstate_ff == H_MOD && hstate_in == H_DONE) begin
         bkt_ff  <= h_ff[BktW-1:0];
         fill_ff <= (fill_mem_ff[h_ff[BktW-1:0]] > FillW'(BucketDepth)) ?
                    FillW'(BucketDepth) : fill_mem_ff[h_ff[BktW-1:0]];
         pos_ff  <= '0;
         full_ff <= fill_mem_ff[h_ff[BktW-1:0]] >= FillW'(BucketDepth);
      end
      if (cmd.chk && k_rd == key_ff) begin
         hit_ff <= 1'b1;
         if (mode_ff != MODE_SET) vout_ff <= v_rd;
      end
      if (cmd.pos_inc || cmd.shift_wr) pos_ff <= pos_ff + 1'b1;
      if (cmd.commit) stat_ff <= (mode_ff == MODE_SET) && !hit_ff && full_ff;
   end

   // set writes at hit position or at fill (pos == fill when no hit)
   always_comb begin
      rd_addr = {bkt_ff, pos_ff[PosW-1:0]};
      if (cmd.shift_rd) rd_addr = {bkt_ff, pos_ff[PosW-1:0] + PosW'(1)};
      wr_en = cmd.wr_set || cmd.shift_wr;
      wr_addr = {bkt_ff, pos_ff[PosW-1:0]};
      k_wd = cmd.shift_wr ? k_rd : key_ff;
      v_wd = cmd.shift_wr ? v_rd : val_ff;
   end

   ikh_ram #(.Width(32), .Depth(SlotTotal)) u_keys (
      .clock, .wr_en, .wr_addr, .wr_data(k_wd), .rd_addr, .rd_data(k_rd));
   ikh_ram #(.Width(32), .Depth(SlotTotal)) u_vals (
      .clock, .wr_en, .wr_addr, .wr_data(v_wd), .rd_addr, .rd_data(v_rd));

   assign sts.hash_done = (hstate_ff == H_DONE);
   assign sts.at_fill   = (pos_ff == fill_ff);
   assign sts.hit       = (k_rd == key_ff);
   assign sts.full      = full_ff;
   assign sts.shift_end = (pos_ff + 1'b1 >= fill_ff);
   assign sts.mode      = mode_ff;

   assign res_found  = hit_ff;
   assign res_value  = vout_ff;
   assign res_status = stat_ff;
   assign res_bucket = 4'(bkt_ff);
   assign res_count  = total_ff;
endmodule

// ===== rtl/ikh_ctrl.sv =====
// Controller: sequences hash, bucket scan, write or shift, and result transfer.
// Depends on ikh_pkg.
`timescale 1ns / 1ps
module ikh_ctrl
   import ikh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ikh_sts_type sts,
   output ikh_cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_HASH, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_COMMIT, S_RESP
   } state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.start = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: if (sts.hash_done) state_in = S_READ;
         S_READ: begin
            if (sts.at_fill) begin
               if (sts.mode == MODE_SET && !sts.full) cmd.wr_set = 1'b1;
               state_in = S_COMMIT;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.chk = 1'b1;
            if (sts.hit) begin
               unique case (sts.mode)
                  MODE_SET: begin
                     cmd.wr_set = 1'b1;
                     state_in = S_COMMIT;
                  end
                  MODE_DEL: state_in = sts.shift_end ? S_COMMIT : S_SHIFT_RD;
                  default:  state_in = S_COMMIT;
               endcase
            end else begin
               cmd.pos_inc = 1'b1;
               state_in = S_READ;
            end
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = 1'b1;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in = sts.shift_end ? S_COMMIT : S_SHIFT_RD;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== rtl/int_key_chained_hash_table_unit.sv =====
// Channel   Dir  Transfer when
// req       in   req_valid && req_ready (mode, key, value)
// rsp       out  rsp_valid && rsp_ready (found, value_out, status, bucket_index, entry_count)
// csr       in   psel && penable && pwrite (bucket_count at 0x0)
// One operation at a time: the hash text is formed, then the modulo (one
// compare-subtract per cycle), then the fill is loaded, then each entry is scanned,
// on delete each later entry is moved, a miss takes one more step, and the commit
// and the raising of the result follow. Synchronous reset clears fill counts and
// total; the entry RAMs are not cleared. A request is taken only when no result
// waits or the waiting result transfers in the same cycle; a stalled result holds.
`timescale 1ns / 1ps
`include "int_key_chained_hash_table_unit_assert.svh"
module int_key_chained_hash_table_unit
   import ikh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ikh_req_if.sink     req,
   ikh_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   ikh_cmd_type cmd;
   ikh_sts_type sts;
   logic [4:0]  bucket_count_ff;
   logic        res_found, res_status;
   logic [31:0] res_value;
   logic [3:0]  res_bucket;
   logic [CntW-1:0] res_count;
   logic        rsp_valid_w;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= 5'd10;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == REG_BUCKET_COUNT && csr_paddr[1:0] == 2'd0) begin
         bucket_count_ff <= csr_pwdata[4:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_BUCKET_COUNT) ? {27'd0, bucket_count_ff} : '0;

   ikh_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp_valid_w), .rsp_ready(rsp.ready), .sts, .cmd);

   ikh_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_mode(req.mode), .req_key(req.key),
      .req_value(req.value), .bucket_count(bucket_count_ff),
      .res_found, .res_value, .res_status, .res_bucket, .res_count);

   assign rsp.valid        = rsp_valid_w;
   assign rsp.found        = res_found;
   assign rsp.value_out    = res_value;
   assign rsp.status       = res_status;
   assign rsp.bucket_index = res_bucket;
   assign rsp.entry_count  = res_count;

   `IKH_ASSERT_IMP(a_status_no_found, clock, reset, rsp_valid_w && res_status, !res_found, "full with found")
   `IKH_ASSERT_IMP(a_count_max, clock, reset, rsp_valid_w, res_count <= CntW'(SlotTotal), "count too high")
   `IKH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_w && !rsp.ready, rsp_valid_w && $stable(res_value), "rsp not held")
endmodule
